// ===== hdl/lts_pkg.sv =====
//------------------------------------------------------------------------------
// lts_pkg
// Types, character codes and helper functions shared by the token scanner.
//------------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

	// Width of the byte offset counter and the width of the reported fields.
	localparam int OFFSET_WIDTH = 16;
	localparam int FIELD_W      = 16;
	localparam int KIND_W       = 3;

	// Result queue depth; a byte needs room for two results to enter.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_SPECIAL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SPLICE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STRING  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ATOM    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef enum logic [2:0] {
		MODE_WS,
		MODE_ATOM,
		MODE_STRING,
		MODE_COMMENT,
		MODE_TILDE
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]  token_kind;
		logic [FIELD_W-1:0] token_start;
		logic [FIELD_W-1:0] token_length;
		logic               open_string;
		logic               offset_overflow;
		logic               last_result;
	} tok_t;

	// Results produced by one byte: how many, and the first two slots in order.
	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	function automatic logic is_space(input logic [7:0] b);
		is_space = b inside {CH_COMMA, CH_SPACE, CH_TAB, CH_LF};
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		is_special = b inside {CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
			CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_BTICK, CH_TILDE, CH_CARET, CH_AT};
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		is_delim = b inside {CH_SPACE, CH_TAB, CH_LF, CH_COMMA, CH_SEMI,
			CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
			CH_QUOTE, CH_BTICK, CH_DQUOTE};
	endfunction

	// Length from start to end, plus an optional extra byte, clamped to OFF_MAX.
	function automatic logic [FIELD_W-1:0] tok_len(
		input logic [OFFSET_WIDTH-1:0] first,
		input logic [OFFSET_WIDTH-1:0] last_off,
		input logic                    plus_one
	);
		logic [OFFSET_WIDTH:0] diff;
		logic [OFFSET_WIDTH-1:0] clamped;
		diff = {1'b0, last_off} - {1'b0, first} + {{OFFSET_WIDTH{1'b0}}, plus_one};
		if (diff > {1'b0, OFF_MAX}) begin
			clamped = OFF_MAX;
		end else begin
			clamped = diff[OFFSET_WIDTH-1:0];
		end
		tok_len = FIELD_W'(clamped);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lts_if.sv =====
//------------------------------------------------------------------------------
// lts_if
// Valid/ready channels for source bytes and for scanned tokens.
//------------------------------------------------------------------------------
`default_nettype none

interface lts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface lts_tok_if;
	import lts_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  token_kind;
	logic [FIELD_W-1:0] token_start;
	logic [FIELD_W-1:0] token_length;
	logic               open_string;
	logic               offset_overflow;
	logic               last_result;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output open_string, output offset_overflow,
		output last_result, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input open_string, input offset_overflow,
		input last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/lisp_token_scanner.sv =====
//------------------------------------------------------------------------------
// lisp_token_scanner
// Streaming lexer for Lisp source text: one byte in, zero to two tokens out.
//------------------------------------------------------------------------------
// The scanner takes one source byte per request on text_in and reports tokens
// on token_out as start offset, length and kind; a zero byte ends the text,
// gives a final request with last_result set and returns the scanner to its
// reset state. A byte enters every clock while the result queue has room, so
// the sustained rate is one byte per cycle for ordinary text when token_out
// is always ready. A byte that ends an atom or a pending tilde and is itself a
// token, or a zero byte that ends an atom or a pending tilde, yields two
// requests; since token_out drains one request per cycle, such bytes build a
// backlog, and input is refused while the queue holds three or more entries
// (as it also is when token_out stalls). The first token of a byte reaches
// token_out through the byte register and then the four-entry result queue,
// which the scan logic writes once the queue has room and whose head drives
// token_out directly.
//------------------------------------------------------------------------------
`default_nettype none

module lisp_token_scanner (
	input  wire logic clk,
	input  wire logic arst_n,
	lts_byte_if.sink  text_in,
	lts_tok_if.source token_out
);
	import lts_pkg::*;

	// Results of the byte being scanned, and whether the queue can take two.
	push_t push;
	logic  room;

	// Byte register and scan-mode state: whitespace, atom, string, comment and
	// pending tilde, plus the escape flag, token start and running offset.
	lts_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.room    (room),
		.push    (push)
	);

	// Result queue; a byte is scanned only when two free slots are certain,
	// so no token is ever dropped whatever token_out.ready does.
	lts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.token_out (token_out)
	);

endmodule

`default_nettype wire

// ===== hdl/lts_core.sv =====
//------------------------------------------------------------------------------
// lts_core
// Input byte register and the scan-mode logic that turns one byte into up to
// two tokens.
//------------------------------------------------------------------------------
`default_nettype none

module lts_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lts_byte_if.sink           text_in,
	input  wire logic          room,
	output lts_pkg::push_t     push
);
	import lts_pkg::*;

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    consume;

	mode_t                   mode_q, mode_nx;
	logic                    esc_q, esc_nx;
	logic [OFFSET_WIDTH-1:0] start_q, start_nx;
	logic [OFFSET_WIDTH-1:0] cur_q, cur_nx;
	logic                    sat_q, sat_nx;

	assign consume       = valid_s1 && room;
	assign text_in.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WS;
			esc_q   <= 1'b0;
			start_q <= '0;
			cur_q   <= '0;
			sat_q   <= 1'b0;
		end else if (consume) begin
			mode_q  <= mode_nx;
			esc_q   <= esc_nx;
			start_q <= start_nx;
			cur_q   <= cur_nx;
			sat_q   <= sat_nx;
		end
	end

	always_comb begin
		tok_t       res [2];
		tok_t       base;
		logic [1:0] n;
		logic       ws_path;

		base                 = '0;
		base.offset_overflow = sat_q;
		res[0]               = base;
		res[1]               = base;
		n                    = 2'd0;
		ws_path              = 1'b0;
		mode_nx              = mode_q;
		esc_nx               = esc_q;
		start_nx             = start_q;
		sat_nx               = sat_q;

		if (cur_q == OFF_MAX) begin
			cur_nx = cur_q;
			sat_nx = 1'b1;
		end else begin
			cur_nx = cur_q + 1'b1;
		end

		if (byte_s1 == CH_NUL) begin
			// End of text: flush a pending atom or tilde, then the final result.
			if (mode_q == MODE_ATOM) begin
				res[0].token_kind   = KIND_ATOM;
				res[0].token_start  = FIELD_W'(start_q);
				res[0].token_length = tok_len(start_q, cur_q, 1'b0);
				n = 2'd1;
			end else if (mode_q == MODE_TILDE) begin
				res[0].token_kind   = KIND_SPECIAL;
				res[0].token_start  = FIELD_W'(start_q);
				res[0].token_length = FIELD_W'(1);
				n = 2'd1;
			end
			res[n[0]].token_kind   = KIND_END;
			res[n[0]].token_start  = FIELD_W'(cur_q);
			res[n[0]].token_length = '0;
			res[n[0]].open_string  = (mode_q == MODE_STRING);
			res[n[0]].last_result  = 1'b1;
			n        = n + 2'd1;
			mode_nx  = MODE_WS;
			esc_nx   = 1'b0;
			start_nx = '0;
			cur_nx   = '0;
			sat_nx   = 1'b0;
		end else begin
			case (mode_q)
				MODE_ATOM: begin
					if (is_delim(byte_s1)) begin
						res[0].token_kind   = KIND_ATOM;
						res[0].token_start  = FIELD_W'(start_q);
						res[0].token_length = tok_len(start_q, cur_q, 1'b0);
						n       = 2'd1;
						mode_nx = MODE_WS;
						ws_path = 1'b1;
					end
				end
				MODE_STRING: begin
					if (esc_q) begin
						esc_nx = 1'b0;
					end else if (byte_s1 == CH_DQUOTE) begin
						res[0].token_kind   = KIND_STRING;
						res[0].token_start  = FIELD_W'(start_q);
						res[0].token_length = tok_len(start_q, cur_q, 1'b1);
						n       = 2'd1;
						mode_nx = MODE_WS;
					end else if (byte_s1 == CH_BSLASH) begin
						esc_nx = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (byte_s1 == CH_LF) begin
						mode_nx = MODE_WS;
					end
				end
				MODE_TILDE: begin
					res[0].token_start = FIELD_W'(start_q);
					n       = 2'd1;
					mode_nx = MODE_WS;
					if (byte_s1 == CH_AT) begin
						res[0].token_kind   = KIND_SPLICE;
						res[0].token_length = FIELD_W'(2);
					end else begin
						res[0].token_kind   = KIND_SPECIAL;
						res[0].token_length = FIELD_W'(1);
						ws_path = 1'b1;
					end
				end
				default: begin
					mode_nx = MODE_WS;
					ws_path = 1'b1;
				end
			endcase

			// Whitespace-mode handling, also for a byte that ended a token.
			if (ws_path && !is_space(byte_s1)) begin
				start_nx = cur_q;
				if (byte_s1 == CH_SEMI) begin
					mode_nx = MODE_COMMENT;
				end else if (byte_s1 == CH_DQUOTE) begin
					mode_nx = MODE_STRING;
					esc_nx  = 1'b0;
				end else if (byte_s1 == CH_TILDE) begin
					mode_nx = MODE_TILDE;
				end else if (is_special(byte_s1)) begin
					res[n[0]].token_kind   = KIND_SPECIAL;
					res[n[0]].token_start  = FIELD_W'(cur_q);
					res[n[0]].token_length = FIELD_W'(1);
					n = n + 2'd1;
				end else begin
					mode_nx = MODE_ATOM;
				end
			end
		end

		push.count = consume ? n : 2'd0;
		push.tok0  = res[0];
		push.tok1  = res[1];
	end

endmodule

`default_nettype wire

// ===== hdl/lts_fifo.sv =====
//------------------------------------------------------------------------------
// lts_fifo
// Small result queue that takes up to two tokens a cycle and hands out one.
//------------------------------------------------------------------------------
`default_nettype none

module lts_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lts_pkg::push_t push,
	output logic                room,
	lts_tok_if.source           token_out
);
	import lts_pkg::*;

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] tail_p1;
	tok_t             head_tok;

	assign pop      = token_out.valid && token_out.ready;
	assign room     = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign tail_p1  = tail_q + 1'b1;
	assign head_tok = mem_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			tail_q  <= tail_q + PTR_W'(push.count);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[tail_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem_q[tail_p1] <= push.tok1;
		end
	end

	assign token_out.valid           = count_q != '0;
	assign token_out.token_kind      = head_tok.token_kind;
	assign token_out.token_start     = head_tok.token_start;
	assign token_out.token_length    = head_tok.token_length;
	assign token_out.open_string     = head_tok.open_string;
	assign token_out.offset_overflow = head_tok.offset_overflow;
	assign token_out.last_result     = head_tok.last_result;

endmodule

`default_nettype wire

// ===== hdl/lts_checker.sv =====
//------------------------------------------------------------------------------
// lts_checker
// Port-level checks on the token scanner, bound to its top level.
//------------------------------------------------------------------------------
`default_nettype none

module lts_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lts_pkg::KIND_W-1:0]  token_kind,
	input wire logic [lts_pkg::FIELD_W-1:0] token_length,
	input wire logic                        open_string,
	input wire logic                        last_result
);
	import lts_pkg::*;

	// A stalled token request keeps its kind and length.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_length))
		else $error("token request changed while stalled");

	// The final request of a text is an end marker with zero length.
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> token_kind == KIND_END && token_length == '0)
		else $error("final request is not an empty end marker");

	// Only the end marker reports an unfinished string.
	a_open_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_string |-> last_result)
		else $error("open_string set on an ordinary token");

	// Special tokens are one byte long, splice tokens two.
	a_fixed_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_SPECIAL || token_kind == KIND_SPLICE) |->
		token_length == ((token_kind == KIND_SPLICE) ? FIELD_W'(2) : FIELD_W'(1)))
		else $error("special or splice token has wrong length");

endmodule

bind lisp_token_scanner lts_checker u_lts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (token_out.valid),
	.out_ready    (token_out.ready),
	.token_kind   (token_out.token_kind),
	.token_length (token_out.token_length),
	.open_string  (token_out.open_string),
	.last_result  (token_out.last_result)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the Lisp token scanner: random and directed text is
// streamed in byte by byte, and every token request is compared with the
// tokens that a behavioral lexer in this file expects for the same bytes.
//------------------------------------------------------------------------------

module tb;
	import lts_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	lts_byte_if text_in();
	lts_tok_if  token_out();

	lisp_token_scanner u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.token_out (token_out)
	);

	always #5 clk = ~clk;

	// Bytes still to be offered, and tokens predicted but not yet seen.
	logic [7:0] text_plan[$];
	tok_t       tokens_due[$];

	int unsigned err_cnt      = 0;
	int unsigned tokens_taken = 0;

	// Free-running cycle count. One window in four runs with no idling on either
	// side, so back-to-back traffic is exercised as well as gappy traffic.
	logic [31:0] cyc = '0;
	logic        steady;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	assign steady = (cyc[10:9] == 2'b11);

	// The eleven characters that form a token on their own.
	logic [7:0] punct_set [11] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
		CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_BTICK, CH_TILDE, CH_CARET, CH_AT};

	//--------------------------------------------------------------------------
	// Behavioral lexer
	//--------------------------------------------------------------------------
	mode_t                   lex_mode;
	logic                    esc_armed;
	logic [OFFSET_WIDTH-1:0] tok_first;
	logic [OFFSET_WIDTH-1:0] cur_off;
	logic                    sat_seen;

	function automatic logic blank_ch(input logic [7:0] b);
		case (b)
			CH_COMMA, CH_SPACE, CH_TAB, CH_LF: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic punct_ch(input logic [7:0] b);
		foreach (punct_set[i]) begin
			if (punct_set[i] == b) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Bytes that end an atom. Note that ~ ^ @ do not: they stay inside an atom.
	function automatic logic stop_ch(input logic [7:0] b);
		if (blank_ch(b)) begin
			return 1'b1;
		end
		case (b)
			CH_SEMI, CH_DQUOTE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
			CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_BTICK: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic lex_clear();
		lex_mode  = MODE_WS;
		esc_armed = 1'b0;
		tok_first = '0;
		cur_off   = '0;
		sat_seen  = 1'b0;
	endtask

	// Queues one expected token. Lengths clamp at the largest offset, and the
	// overflow flag is whatever the lexer holds when the token is formed.
	task automatic push_tok(input logic [KIND_W-1:0] kind,
		input logic [OFFSET_WIDTH-1:0] first, input int unsigned len,
		input logic open, input logic last);
		tok_t t;
		t.token_kind      = kind;
		t.token_start     = FIELD_W'(first);
		t.token_length    = (len > OFF_MAX) ? FIELD_W'(OFF_MAX) : FIELD_W'(len);
		t.open_string     = open;
		t.offset_overflow = sat_seen;
		t.last_result     = last;
		tokens_due.push_back(t);
	endtask

	// A nonzero byte seen between tokens: either skipped, emitted as a one-byte
	// token, or the opening byte of a longer construct.
	task automatic lex_fresh(input logic [7:0] b);
		if (blank_ch(b)) begin
			return;
		end
		tok_first = cur_off;
		if (b == CH_SEMI) begin
			lex_mode = MODE_COMMENT;
		end else if (b == CH_DQUOTE) begin
			lex_mode  = MODE_STRING;
			esc_armed = 1'b0;
		end else if (b == CH_TILDE) begin
			lex_mode = MODE_TILDE;
		end else if (punct_ch(b)) begin
			push_tok(KIND_SPECIAL, cur_off, 1, 1'b0, 1'b0);
		end else begin
			lex_mode = MODE_ATOM;
		end
	endtask

	task automatic lex_byte(input logic [7:0] b);
		logic open;
		int unsigned span;
		open = 1'b0;
		span = 32'(cur_off) - 32'(tok_first);
		if (b == CH_NUL) begin
			// End of text flushes a pending atom or tilde first. A comment just
			// disappears, and an unclosed string only raises open_string.
			case (lex_mode)
				MODE_ATOM:   push_tok(KIND_ATOM, tok_first, span, 1'b0, 1'b0);
				MODE_TILDE:  push_tok(KIND_SPECIAL, tok_first, 1, 1'b0, 1'b0);
				MODE_STRING: open = 1'b1;
				default: ;
			endcase
			push_tok(KIND_END, cur_off, 0, open, 1'b1);
			lex_clear();
			return;
		end
		case (lex_mode)
			MODE_ATOM: begin
				// The delimiter is scanned again at once and may be a token itself.
				if (stop_ch(b)) begin
					push_tok(KIND_ATOM, tok_first, span, 1'b0, 1'b0);
					lex_mode = MODE_WS;
					lex_fresh(b);
				end
			end
			MODE_STRING: begin
				if (esc_armed) begin
					esc_armed = 1'b0;
				end else if (b == CH_DQUOTE) begin
					push_tok(KIND_STRING, tok_first, span + 1, 1'b0, 1'b0);
					lex_mode = MODE_WS;
				end else if (b == CH_BSLASH) begin
					esc_armed = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (b == CH_LF) begin
					lex_mode = MODE_WS;
				end
			end
			MODE_TILDE: begin
				lex_mode = MODE_WS;
				if (b == CH_AT) begin
					push_tok(KIND_SPLICE, tok_first, 2, 1'b0, 1'b0);
				end else begin
					push_tok(KIND_SPECIAL, tok_first, 1, 1'b0, 1'b0);
					lex_fresh(b);
				end
			end
			default: begin
				lex_mode = MODE_WS;
				lex_fresh(b);
			end
		endcase
		// The offset sticks at its maximum; the flag marks a byte taken there.
		if (cur_off == OFF_MAX) begin
			sat_seen = 1'b1;
		end else begin
			cur_off = cur_off + 1'b1;
		end
	endtask

	//--------------------------------------------------------------------------
	// Idle lengths: mostly none, some short, a few long.
	//--------------------------------------------------------------------------
	function automatic int unsigned idle_len();
		int unsigned r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 20);
	endfunction

	//--------------------------------------------------------------------------
	// Byte driver. A request is held until it is taken; each taken byte goes
	// through the lexer right away, so the expected tokens are queued in the
	// order the scanner has to produce them.
	//--------------------------------------------------------------------------
	int unsigned send_idle;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_in.valid     <= 1'b0;
			text_in.text_byte <= '0;
			send_idle = 0;
			lex_clear();
		end else begin
			if (text_in.valid && text_in.ready) begin
				lex_byte(text_in.text_byte);
			end
			if (text_in.valid && !text_in.ready) begin
				// Request still pending: hold byte and valid steady.
			end else if (send_idle != 0) begin
				send_idle--;
				text_in.valid <= 1'b0;
			end else if (text_plan.size() != 0) begin
				text_in.valid     <= 1'b1;
				text_in.text_byte <= text_plan.pop_front();
				send_idle = idle_len();
			end else begin
				text_in.valid <= 1'b0;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Token monitor. Each taken request is compared field by field with the
	// oldest expected token. Ready drops for random stretches after a request,
	// and once for a long hold so that the four-entry result queue fills and
	// the scanner has to refuse input bytes for a while.
	//--------------------------------------------------------------------------
	int unsigned stall_left;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: token %0d: %s: got %0h, expected %0h",
			$time, tokens_taken, what, got, want);
		err_cnt++;
	endtask

	task automatic check_token();
		tok_t want;
		if (tokens_due.size() == 0) begin
			flag_mismatch("token with none expected", 32'(token_out.token_start),
				32'(0));
			return;
		end
		want = tokens_due.pop_front();
		if (token_out.token_kind !== want.token_kind)
			flag_mismatch("token_kind", 32'(token_out.token_kind),
				32'(want.token_kind));
		if (token_out.token_start !== want.token_start)
			flag_mismatch("token_start", 32'(token_out.token_start),
				32'(want.token_start));
		if (token_out.token_length !== want.token_length)
			flag_mismatch("token_length", 32'(token_out.token_length),
				32'(want.token_length));
		if (token_out.open_string !== want.open_string)
			flag_mismatch("open_string", 32'(token_out.open_string),
				32'(want.open_string));
		if (token_out.offset_overflow !== want.offset_overflow)
			flag_mismatch("offset_overflow", 32'(token_out.offset_overflow),
				32'(want.offset_overflow));
		if (token_out.last_result !== want.last_result)
			flag_mismatch("last_result", 32'(token_out.last_result),
				32'(want.last_result));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_out.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (token_out.valid && token_out.ready) begin
				check_token();
				tokens_taken++;
				stall_left = (tokens_taken == 40) ? 300 : idle_len();
			end
			if (stall_left != 0) begin
				stall_left--;
				token_out.ready <= 1'b0;
			end else begin
				token_out.ready <= 1'b1;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Stimulus building blocks
	//--------------------------------------------------------------------------
	task automatic put(input logic [7:0] b);
		text_plan.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put(s[i]);
		end
	endtask

	function automatic logic [7:0] rand_nz();
		return 8'($urandom_range(1, 255));
	endfunction

	// A byte that may sit inside an atom; the opening byte must also not be a
	// one-byte token character, or it would never start an atom.
	function automatic logic [7:0] atom_ch(input bit opening);
		logic [7:0] b;
		do begin
			b = rand_nz();
		end while (stop_ch(b) || (opening && punct_ch(b)));
		return b;
	endfunction

	task automatic add_gap();
		int unsigned n;
		n = $urandom_range(1, 2);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: put(CH_SPACE);
				1: put(CH_TAB);
				2: put(CH_LF);
				default: put(CH_COMMA);
			endcase
		end
	endtask

	// One lexical piece with random content. When closed is clear, a string
	// or comment is left open so that the text ends inside it.
	task automatic add_piece(input bit closed);
		int unsigned n;
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				put(atom_ch(1'b1));
				n = $urandom_range(0, 5);
				repeat (n) put(atom_ch(1'b0));
			end
			3: begin
				put(CH_DQUOTE);
				n = $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						// Escaped byte, often a quote or another backslash.
						put(CH_BSLASH);
						case ($urandom_range(0, 2))
							0: put(CH_DQUOTE);
							1: put(CH_BSLASH);
							default: put(rand_nz());
						endcase
					end else begin
						do begin
							b = rand_nz();
						end while (b == CH_DQUOTE || b == CH_BSLASH);
						put(b);
					end
				end
				if (closed) begin
					put(CH_DQUOTE);
				end
			end
			4: begin
				put(CH_SEMI);
				n = $urandom_range(0, 6);
				repeat (n) begin
					do begin
						b = rand_nz();
					end while (b == CH_LF);
					put(b);
				end
				if (closed) begin
					put(CH_LF);
				end
			end
			5, 6: put(punct_set[$urandom_range(0, 10)]);
			7: begin
				put(CH_TILDE);
				put(CH_AT);
			end
			8: begin
				n = $urandom_range(1, 4);
				repeat (n) put(rand_nz());
			end
			default: begin
				put(CH_TILDE);
				put(rand_nz());
			end
		endcase
	endtask

	//--------------------------------------------------------------------------
	// Main sequence
	//--------------------------------------------------------------------------
	initial begin
		int unsigned rand_goal;
		int unsigned n;
		bit broken;

		arst_n = 1'b0;

		// Directed text: one-byte tokens, splice, a tilde followed by a token
		// and by an atom, an atom ended by a token character, the extreme byte
		// values, an escaped quote, a comment, skipped blanks, and a tilde left
		// pending at the end of the text.
		put_str("(~@");
		put(8'hFF);
		put_str(")~(~b\"x\\\"y\";c\n,\t~");
		put(CH_NUL);
		// Text ending inside an atom.
		put(8'h01);
		put(CH_NUL);
		// Text ending right after a backslash inside a string.
		put_str("\"\\");
		put(CH_NUL);
		// Text ending inside a comment, then an empty text.
		put(CH_SEMI);
		put(CH_NUL);
		put(CH_NUL);

		// Random texts, mostly well formed, one in ten cut off mid-piece.
		rand_goal = text_plan.size() + 620;
		while (text_plan.size() < rand_goal) begin
			n      = $urandom_range(1, 12);
			broken = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 2) != 0) begin
					add_gap();
				end
				add_piece(!(broken && i == n - 1));
			end
			put(CH_NUL);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Polling on the falling edge sees settled values from the rising edge.
		while (text_plan.size() != 0 || text_in.valid) @(negedge clk);
		while (tokens_due.size() != 0) @(negedge clk);
		// Then wait on, in case the scanner produces something unasked.
		repeat (16) @(posedge clk);

		if (err_cnt == 0 && tokens_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of under a thousand bytes.
	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
